// ----- hw/rtl/flfq_pkg.sv -----
// Types and constants shared by the fetch queue core and its checker.
package flfq_pkg;

    // Field widths fixed by the word formats
    localparam int WORD_W       = 32;
    localparam int LOAD_INDEX_W = 12;
    localparam int COUNT_W      = 3;
    localparam int RESULT_WORDS = 4;

    // Word address bits of a byte address (byte address without its low two bits)
    localparam int WADDR_W = WORD_W - 2;

    // Countdown of a slot and the value a new fetch starts from
    localparam int            CD_W         = 2;
    localparam logic [CD_W-1:0] FILL_LATENCY = 2'd3;

    // Remainder unit: multiply by the reciprocal, multiply back, subtract
    localparam int MOD_STEPS = 3;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic                    squash;
        logic                    consumed;
        logic                    fetch_valid;
        logic [WORD_W-1:0]       fetch_addr;
        logic [LOAD_INDEX_W-1:0] load_index;
        logic [WORD_W-1:0]       load_data;
    } flfq_item_t;

    typedef struct packed {
        logic               line_ready;
        logic [WORD_W-1:0]  line_addr;
        logic [WORD_W-1:0]  word_zero;
        logic [WORD_W-1:0]  word_one;
        logic [WORD_W-1:0]  word_two;
        logic [WORD_W-1:0]  word_three;
        logic [COUNT_W-1:0] queue_count;
        logic               fetch_dropped;
    } flfq_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_LOAD,
        ST_FILL,
        ST_READ,
        ST_RESP
    } flfq_state_t;

endpackage

// ----- hw/rtl/fixed_latency_fetch_queue_core.sv -----
// Fixed-latency instruction fetch queue: slot control, backing memory and line storage.
//
// The block keeps a ring of QUEUE_DEPTH line requests. A tick word may squash the ring, pop the
// head slot and claim the slot after the last valid one for a new line fetch; a claimed slot
// counts down from 3 and, on the tick where it reaches zero, is filled with LINE_WORDS words
// read from the internal backing memory. A load word writes one word of that memory. Every
// word gives exactly one result word showing the head slot and occupancy after it. Words are
// taken one at a time. With MEM_WORDS a power of two, a plain tick goes through the read and
// response states, a tick that completes a countdown first fills the line from the backing
// memory (the backing memory has one port and gives one word a cycle), and a load first
// writes one word of the backing memory. With any other MEM_WORDS, a load and a filling tick
// also pass through a remainder unit that reduces the word address modulo MEM_WORDS by
// reciprocal multiplication. The result sits in an output register, so the next word is
// accepted while the previous result waits to be taken. The backing memory is undefined
// until loaded and is not cleared after reset.
module fixed_latency_fetch_queue_core #(
    parameter int QUEUE_DEPTH = 4,
    parameter int LINE_WORDS  = 4,
    parameter int MEM_WORDS   = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  flfq_pkg::flfq_item_t  item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output flfq_pkg::flfq_result_t result
);
    import flfq_pkg::*;

    localparam int  HEAD_W   = $clog2(QUEUE_DEPTH);
    localparam int  SUM_W    = HEAD_W + 1;
    localparam int  OCC_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int  ADDR_W   = $clog2(MEM_WORDS);
    localparam int  WSEL_W   = $clog2(LINE_WORDS + 1);
    localparam int  ROW_W    = LINE_WORDS * WORD_W;
    localparam int  OUT_WORDS = (LINE_WORDS < RESULT_WORDS) ? LINE_WORDS : RESULT_WORDS;
    localparam bit  MEM_POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

    // Reciprocal of MEM_WORDS scaled by 2^MOD_SHIFT; the quotient estimate is short by at most one
    localparam int  MOD_SHIFT = WADDR_W + ADDR_W;
    localparam int  RECIP_W   = WADDR_W + 1;
    localparam int  PROD_W    = WADDR_W + RECIP_W;
    localparam int  Q_W       = PROD_W - MOD_SHIFT;
    localparam logic [63:0]        RECIP_FULL = (64'd1 << MOD_SHIFT) / 64'(MEM_WORDS);
    localparam logic [RECIP_W-1:0] RECIP      = RECIP_FULL[RECIP_W-1:0];

    // Storage: backing memory and one line row per slot
    logic [WORD_W-1:0] backing_mem [MEM_WORDS];
    logic [ROW_W-1:0]  slot_mem    [QUEUE_DEPTH];

    // Sequencer and slot control
    flfq_state_t              state_reg, state_next;
    logic [QUEUE_DEPTH-1:0]   valid_reg, valid_next;
    logic [CD_W-1:0]          cd_reg     [QUEUE_DEPTH];
    logic [CD_W-1:0]          cd_next    [QUEUE_DEPTH];
    logic [WORD_W-1:0]        addr_reg   [QUEUE_DEPTH];
    logic [WORD_W-1:0]        addr_next  [QUEUE_DEPTH];
    logic [HEAD_W-1:0]        head_reg, head_next;
    logic                     kind_reg, kind_next;
    logic                     result_valid_reg, result_valid_next;
    logic [MOD_CNT_W-1:0]     mod_cnt_reg, mod_cnt_next;
    logic [WSEL_W-1:0]        fill_cnt_reg, fill_cnt_next;
    logic                     rd_pend_reg, rd_pend_next;

    // Datapath registers
    logic [WADDR_W-1:0]       x_reg, x_next;
    logic [ADDR_W-1:0]        rem_reg, rem_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [WADDR_W-1:0]       qm_reg, qm_next;
    logic [WADDR_W-1:0]       fill_base_reg, fill_base_next;
    logic [HEAD_W-1:0]        fill_slot_reg, fill_slot_next;
    logic [WORD_W-1:0]        line_buf_reg  [LINE_WORDS];
    logic [WORD_W-1:0]        line_buf_next [LINE_WORDS];
    logic [WORD_W-1:0]        load_data_reg, load_data_next;
    logic                     drop_reg, drop_next;
    flfq_result_t             result_reg, result_next;
    logic [WORD_W-1:0]        bmem_rdata_reg;
    logic [ROW_W-1:0]         smem_rdata_reg;

    // Tick decode
    logic [OCC_W-1:0]         occ;
    logic                     full;
    logic                     fill_hit;
    logic [HEAD_W-1:0]        fill_slot;
    logic [SUM_W-1:0]         fetch_sum;
    logic [HEAD_W-1:0]        fetch_slot;
    logic [HEAD_W-1:0]        head_inc;
    logic                     tick_drop;

    // Memory port controls
    logic                     bmem_we, bmem_re;
    logic [ADDR_W-1:0]        bmem_addr;
    logic                     smem_we, smem_re;
    logic [ROW_W-1:0]         line_row;
    logic                     ctl_we;
    logic                     result_load;

    // Fill address and remainder
    logic [WADDR_W:0]         fill_wsum;
    logic                     fill_carry;
    logic [Q_W-1:0]           mod_q;
    logic [WADDR_W-1:0]       mod_diff;

    // Head view for the result word
    logic                     head_ready;
    logic [WORD_W-1:0]        head_words [RESULT_WORDS];

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Tick decode: every update comes from the state before the tick.
    // Countdown updates are applied last so they win over pop and fetch.
    always_comb
    begin
        occ       = OCC_W'($countones(valid_reg));
        full      = (occ == OCC_W'(QUEUE_DEPTH));
        fill_hit  = 1'b0;
        fill_slot = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (valid_reg[i] && cd_reg[i] == CD_W'(1))
            begin
                fill_hit  = 1'b1;
                fill_slot = HEAD_W'(i);
            end
        end

        fetch_sum = SUM_W'(head_reg) + SUM_W'(occ);
        if (fetch_sum >= SUM_W'(QUEUE_DEPTH))
            fetch_sum = fetch_sum - SUM_W'(QUEUE_DEPTH);
        fetch_slot = fetch_sum[HEAD_W-1:0];

        head_inc = (head_reg == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

        valid_next = valid_reg;
        cd_next    = cd_reg;
        addr_next  = addr_reg;
        head_next  = head_reg;
        tick_drop  = 1'b0;

        if (item.squash)
        begin
            valid_next = '0;
            head_next  = '0;
        end
        else
        begin
            if (item.consumed)
            begin
                valid_next[head_reg] = 1'b0;
                cd_next[head_reg]    = '0;
                head_next            = head_inc;
            end
            if (item.fetch_valid)
            begin
                if (full)
                    tick_drop = 1'b1;
                else
                begin
                    cd_next[fetch_slot]    = FILL_LATENCY;
                    addr_next[fetch_slot]  = item.fetch_addr;
                    valid_next[fetch_slot] = 1'b1;
                end
            end
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (valid_reg[i] && cd_reg[i] != '0)
                    cd_next[i] = cd_reg[i] - 1'b1;
            end
        end
    end

    // Word index of the current fill read. When the 30-bit word address wraps,
    // the wrapped index is below LINE_WORDS and needs no reduction.
    assign fill_wsum  = {1'b0, fill_base_reg} + (WADDR_W + 1)'(fill_cnt_reg);
    assign fill_carry = fill_wsum[WADDR_W];

    // Remainder: the quotient estimate is exact or one short, so one subtract finishes it
    always_comb
    begin
        mod_q    = prod_reg[PROD_W-1:MOD_SHIFT];
        mod_diff = x_reg - qm_reg;
        if (mod_diff >= WADDR_W'(MEM_WORDS))
            mod_diff = mod_diff - WADDR_W'(MEM_WORDS);
    end

    // Pack the line buffer into one slot row
    always_comb
    begin
        for (int k = 0; k < LINE_WORDS; k++)
            line_row[k*WORD_W +: WORD_W] = line_buf_reg[k];
    end

    // Head view after the word: words show only once the line is filled
    always_comb
    begin
        head_ready = valid_reg[head_reg] && (cd_reg[head_reg] == '0);
        for (int k = 0; k < RESULT_WORDS; k++)
            head_words[k] = '0;
        for (int k = 0; k < OUT_WORDS; k++)
        begin
            if (head_ready)
                head_words[k] = smem_rdata_reg[k*WORD_W +: WORD_W];
        end
    end

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        mod_cnt_next   = mod_cnt_reg;
        fill_cnt_next  = fill_cnt_reg;
        rd_pend_next   = 1'b0;
        x_next         = x_reg;
        rem_next       = rem_reg;
        prod_next      = prod_reg;
        qm_next        = qm_reg;
        fill_base_next = fill_base_reg;
        fill_slot_next = fill_slot_reg;
        line_buf_next  = line_buf_reg;
        load_data_next = load_data_reg;
        drop_next      = drop_reg;
        ctl_we         = 1'b0;
        bmem_we        = 1'b0;
        bmem_re        = 1'b0;
        bmem_addr      = rem_reg;
        smem_we        = 1'b0;
        smem_re        = 1'b0;
        result_load    = 1'b0;

        result_next.line_ready    = head_ready;
        result_next.line_addr     = valid_reg[head_reg] ? addr_reg[head_reg] : '0;
        result_next.word_zero     = head_words[0];
        result_next.word_one      = head_words[1];
        result_next.word_two      = head_words[2];
        result_next.word_three    = head_words[3];
        result_next.queue_count   = COUNT_W'($countones(valid_reg));
        result_next.fetch_dropped = drop_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    kind_next      = item.kind;
                    load_data_next = item.load_data;
                    mod_cnt_next   = '0;
                    fill_cnt_next  = '0;
                    if (item.kind == KIND_LOAD)
                    begin
                        x_next     = WADDR_W'(item.load_index);
                        drop_next  = 1'b0;
                        state_next = MEM_POW2 ? ST_LOAD : ST_MOD;
                    end
                    else
                    begin
                        ctl_we         = 1'b1;
                        drop_next      = tick_drop;
                        x_next         = addr_reg[fill_slot][WORD_W-1:2];
                        fill_base_next = addr_reg[fill_slot][WORD_W-1:2];
                        fill_slot_next = fill_slot;
                        if (item.squash || !fill_hit)
                            state_next = ST_READ;
                        else
                            state_next = MEM_POW2 ? ST_FILL : ST_MOD;
                    end
                    // Power-of-two memory: the index is just the low bits
                    rem_next = MEM_POW2 ? x_next[ADDR_W-1:0] : '0;
                end
            end

            ST_MOD:
            begin
                // Multiply by the reciprocal, multiply the quotient back, then subtract
                if (mod_cnt_reg == '0)
                    prod_next = PROD_W'(x_reg) * PROD_W'(RECIP);
                else if (mod_cnt_reg == MOD_CNT_W'(1))
                    qm_next = WADDR_W'(mod_q) * WADDR_W'(MEM_WORDS);
                else
                    rem_next = mod_diff[ADDR_W-1:0];
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
                    state_next = (kind_reg == KIND_LOAD) ? ST_LOAD : ST_FILL;
            end

            ST_LOAD:
            begin
                bmem_we    = 1'b1;
                state_next = ST_READ;
            end

            ST_FILL:
            begin
                // Issue one backing read a cycle, shift each word in as it returns
                if (fill_cnt_reg < WSEL_W'(LINE_WORDS))
                begin
                    bmem_re       = 1'b1;
                    bmem_addr     = fill_carry ? fill_wsum[ADDR_W-1:0] : rem_reg;
                    rem_next      = (rem_reg == ADDR_W'(MEM_WORDS - 1)) ? '0 : rem_reg + 1'b1;
                    fill_cnt_next = fill_cnt_reg + 1'b1;
                    rd_pend_next  = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    for (int k = 0; k < LINE_WORDS - 1; k++)
                        line_buf_next[k] = line_buf_reg[k+1];
                    line_buf_next[LINE_WORDS-1] = bmem_rdata_reg;
                end
                if (fill_cnt_reg == WSEL_W'(LINE_WORDS) && !rd_pend_reg)
                begin
                    smem_we    = 1'b1;
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                smem_re    = 1'b1;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                // Hold until the output register is free
                if (!result_valid_reg || !result_stall)
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (result_load)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            valid_reg        <= '0;
            cd_reg           <= '{default: '0};
            head_reg         <= '0;
            kind_reg         <= KIND_TICK;
            result_valid_reg <= 1'b0;
            mod_cnt_reg      <= '0;
            fill_cnt_reg     <= '0;
            rd_pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            kind_reg         <= kind_next;
            result_valid_reg <= result_valid_next;
            mod_cnt_reg      <= mod_cnt_next;
            fill_cnt_reg     <= fill_cnt_next;
            rd_pend_reg      <= rd_pend_next;
            if (ctl_we)
            begin
                valid_reg <= valid_next;
                cd_reg    <= cd_next;
                head_reg  <= head_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        rem_reg       <= rem_next;
        prod_reg      <= prod_next;
        qm_reg        <= qm_next;
        fill_base_reg <= fill_base_next;
        fill_slot_reg <= fill_slot_next;
        line_buf_reg  <= line_buf_next;
        load_data_reg <= load_data_next;
        drop_reg      <= drop_next;
        if (ctl_we)
            addr_reg <= addr_next;
        if (result_load)
            result_reg <= result_next;
    end

    // Backing memory: single port, registered read
    always_ff @(posedge clk)
    begin
        if (bmem_we)
            backing_mem[bmem_addr] <= load_data_reg;
        if (bmem_re)
            bmem_rdata_reg <= backing_mem[bmem_addr];
    end

    // Line storage: write the filled row, then read the head row in the cycle after
    always_ff @(posedge clk)
    begin
        if (smem_we)
            slot_mem[fill_slot_reg] <= line_row;
        if (smem_re)
            smem_rdata_reg <= slot_mem[head_reg];
    end

endmodule

// ----- hw/rtl/flfq_checker.sv -----
// Port-level checker for the fetch queue core, with its bind.
module flfq_port_checker #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  flfq_pkg::flfq_result_t result
);
    import flfq_pkg::*;

    // A stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // One word in flight: an accepted word blocks the next one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second word accepted back to back");

    // Line words show only for a ready head line
    a_words_gated: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.line_ready |->
            result.word_zero == '0 && result.word_one == '0 &&
            result.word_two == '0 && result.word_three == '0)
        else $error("line words not zero without a ready line");

    // A ready head line means the queue is not empty
    a_ready_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.line_ready |->
            (QUEUE_DEPTH >= 8) || (result.queue_count != '0))
        else $error("ready line with an empty queue");

endmodule

bind fixed_latency_fetch_queue_core flfq_port_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_flfq_checker (
    .clk(clk),
    .rst_n(rst_n),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
);

// ----- tb/flfq_checker.sv -----
// Checker for the fetch queue core: tracks queue state, predicts every result word, compares.
module flfq_checker #(
    parameter int QUEUE_DEPTH = 4,
    parameter int LINE_WORDS  = 4,
    parameter int MEM_WORDS   = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  flfq_pkg::flfq_item_t   item,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  flfq_pkg::flfq_result_t result,
    output int                     failures,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import flfq_pkg::*;

    // Shadow of the queue slots, the line storage and the backing memory
    logic              slot_busy  [QUEUE_DEPTH];
    logic [CD_W-1:0]   slot_timer [QUEUE_DEPTH];
    logic [WORD_W-1:0] slot_addr  [QUEUE_DEPTH];
    logic [WORD_W-1:0] slot_data  [QUEUE_DEPTH*LINE_WORDS];
    logic [WORD_W-1:0] mem_image  [MEM_WORDS];
    int                head_slot;

    flfq_result_t      head_views [$];
    int                mismatch_count = 0;

    function automatic flfq_result_t head_view(input logic dropped);
        flfq_result_t      view;
        logic [WORD_W-1:0] words [RESULT_WORDS];
        logic              ready;
        int                n;
        int                i;
        int                base;
        view  = '0;
        n     = 0;
        base  = head_slot * LINE_WORDS;
        ready = slot_busy[head_slot] && (slot_timer[head_slot] == '0);
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (slot_busy[i])
                n++;
        end
        // Words past the end of a short line read as zero
        for (i = 0; i < RESULT_WORDS; i++)
        begin
            words[i] = '0;
            if (ready && i < LINE_WORDS)
                words[i] = slot_data[base + i];
        end
        view.line_ready    = ready;
        view.line_addr     = slot_busy[head_slot] ? slot_addr[head_slot] : '0;
        view.word_zero     = words[0];
        view.word_one      = words[1];
        view.word_two      = words[2];
        view.word_three    = words[3];
        view.queue_count   = COUNT_W'(n);
        view.fetch_dropped = dropped;
        return view;
    endfunction

    // Apply one word to the shadow state; every update reads the state from before the word.
    task automatic advance_queue(input flfq_item_t word, output flfq_result_t view);
        logic              was_busy  [QUEUE_DEPTH];
        logic [CD_W-1:0]   was_timer [QUEUE_DEPTH];
        logic [WORD_W-1:0] was_addr  [QUEUE_DEPTH];
        logic [WORD_W-1:0] fill_addr;
        logic              dropped;
        int                h;
        int                occupied;
        int                slot;
        int                i;
        int                w;
        dropped = 1'b0;
        if (word.kind == KIND_LOAD)
        begin
            mem_image[int'(word.load_index) % MEM_WORDS] = word.load_data;
        end
        else
        begin
            h        = head_slot;
            occupied = 0;
            for (i = 0; i < QUEUE_DEPTH; i++)
            begin
                was_busy[i]  = slot_busy[i];
                was_timer[i] = slot_timer[i];
                was_addr[i]  = slot_addr[i];
                if (slot_busy[i])
                    occupied++;
            end
            if (word.squash)
            begin
                for (i = 0; i < QUEUE_DEPTH; i++)
                    slot_busy[i] = 1'b0;
                head_slot = 0;
            end
            else
            begin
                if (word.consumed)
                begin
                    slot_busy[h]  = 1'b0;
                    slot_timer[h] = '0;
                    head_slot     = (h + 1) % QUEUE_DEPTH;
                end
                if (word.fetch_valid)
                begin
                    // Full before the word means dropped, even with a pop alongside
                    if (occupied >= QUEUE_DEPTH)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        slot             = (h + occupied) % QUEUE_DEPTH;
                        slot_timer[slot] = FILL_LATENCY;
                        slot_addr[slot]  = word.fetch_addr;
                        slot_busy[slot]  = 1'b1;
                    end
                end
                // Countdown last, so it overrides the pop on the same slot
                for (i = 0; i < QUEUE_DEPTH; i++)
                begin
                    if (was_busy[i] && was_timer[i] != '0)
                    begin
                        slot_timer[i] = was_timer[i] - 1'b1;
                        if (slot_timer[i] == '0)
                        begin
                            for (w = 0; w < LINE_WORDS; w++)
                            begin
                                fill_addr = was_addr[i] + WORD_W'(4 * w);
                                slot_data[i*LINE_WORDS + w] =
                                    mem_image[int'(fill_addr[WORD_W-1:2]) % MEM_WORDS];
                            end
                        end
                    end
                end
            end
        end
        view = head_view(dropped);
    endtask

    task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic compare_view(input flfq_result_t want, input flfq_result_t got);
        compare_field("line_ready", WORD_W'(want.line_ready), WORD_W'(got.line_ready));
        compare_field("line_addr", want.line_addr, got.line_addr);
        compare_field("word_zero", want.word_zero, got.word_zero);
        compare_field("word_one", want.word_one, got.word_one);
        compare_field("word_two", want.word_two, got.word_two);
        compare_field("word_three", want.word_three, got.word_three);
        compare_field("queue_count", WORD_W'(want.queue_count), WORD_W'(got.queue_count));
        compare_field("fetch_dropped", WORD_W'(want.fetch_dropped), WORD_W'(got.fetch_dropped));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        flfq_result_t view;
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                slot_busy[i]  = 1'b0;
                slot_timer[i] = '0;
                slot_addr[i]  = '0;
            end
            head_slot = 0;
            head_views.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (result_valid === 1'b1 && result_stall === 1'b0)
            begin
                if (head_views.size() == 0)
                begin
                    $display("%0t: result word mismatch, expected none, actual %h",
                             $time, result);
                    mismatch_count++;
                end
                else
                begin
                    compare_view(head_views.pop_front(), result);
                end
            end
            if (item_valid === 1'b1 && item_stall === 1'b0)
            begin
                advance_queue(item, view);
                head_views.push_back(view);
            end
            failures <= mismatch_count;
            pending  <= head_views.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the fetch queue testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import flfq_pkg::*;

    localparam int QUEUE_DEPTH   = 4;
    localparam int LINE_WORDS    = 4;
    localparam int MEM_WORDS     = 4096;
    localparam int ITEM_TARGET   = 950;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RESET_CYCLES  = 7;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         item_valid   = 1'b0;
    logic         item_stall;
    flfq_item_t   item         = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    flfq_result_t result;
    int           failures;
    int           pending;

    // Knobs shared between the sender and the receiver; written with nonblocking updates
    logic hold_req     = 1'b0;
    int   rx_stall_pct = 38;

    // Sender-side bookkeeping
    int   tx_idle_pct  = 38;
    int   words_sent   = 0;
    bit   word_loaded [MEM_WORDS];
    bit   line_listed [MEM_WORDS];
    int   line_starts [$];

    // Receiver-side hold bookkeeping
    logic hold_seen    = 1'b0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;

    always #1 clk = ~clk;

    fixed_latency_fetch_queue_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LINE_WORDS  (LINE_WORDS),
        .MEM_WORDS   (MEM_WORDS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    flfq_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LINE_WORDS  (LINE_WORDS),
        .MEM_WORDS   (MEM_WORDS)
    ) queue_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .failures     (failures),
        .pending      (pending)
    );

    // Receiver: on a toggle of hold_req, hold off until a counter loaded with HOLD_CYCLES runs out,
    // so the output register fills and the core stalls its input; otherwise stall at random.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Watchdog: end the run once the count of quiet cycles on both channels reaches IDLE_LIMIT.
    // The longest honest quiet stretch is the receiver hold plus a fill, far below this.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Every field random, so the don't-care fields of each kind toggle too
    function automatic flfq_item_t random_word();
        flfq_item_t w;
        w.kind        = 1'($urandom_range(1));
        w.squash      = 1'($urandom_range(1));
        w.consumed    = 1'($urandom_range(1));
        w.fetch_valid = 1'($urandom_range(1));
        w.fetch_addr  = $urandom();
        w.load_index  = LOAD_INDEX_W'($urandom());
        w.load_data   = $urandom();
        return w;
    endfunction

    function automatic bit line_loaded(input int start);
        int k;
        for (k = 0; k < LINE_WORDS; k++)
        begin
            if (!word_loaded[(start + k) % MEM_WORDS])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Pick a fetch address whose whole line was loaded; the bits above and below the
    // word index are free, so randomize them.
    function automatic logic [WORD_W-1:0] fetch_line_addr();
        logic [WORD_W-1:0] addr;
        int                start;
        start = line_starts[$urandom_range(line_starts.size() - 1)];
        addr  = $urandom();
        addr[2 +: LOAD_INDEX_W] = LOAD_INDEX_W'(start);
        return addr;
    endfunction

    // Offer one word after a random idle gap and hold it until accepted.
    // Valid stays high on return, so back-to-back words need no second update.
    task automatic send_word(input flfq_item_t word);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= word;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        words_sent++;
    endtask

    task automatic load_word(input int idx, input logic [WORD_W-1:0] data);
        flfq_item_t w;
        int         k;
        int         start;
        w            = random_word();
        w.kind       = KIND_LOAD;
        w.load_index = LOAD_INDEX_W'(idx);
        w.load_data  = data;
        word_loaded[idx % MEM_WORDS] = 1'b1;
        // Record every line this word completes, so fetches may target it
        for (k = 0; k < LINE_WORDS; k++)
        begin
            start = (idx - k + MEM_WORDS) % MEM_WORDS;
            if (!line_listed[start] && line_loaded(start))
            begin
                line_listed[start] = 1'b1;
                line_starts.push_back(start);
            end
        end
        send_word(w);
    endtask

    task automatic tick_word(input logic squash, input logic consumed, input logic fetch,
                             input logic [WORD_W-1:0] addr);
        flfq_item_t w;
        w             = random_word();
        w.kind        = KIND_TICK;
        w.squash      = squash;
        w.consumed    = consumed;
        w.fetch_valid = fetch;
        w.fetch_addr  = addr;
        send_word(w);
    endtask

    // Drop valid and wait until every predicted result word has been taken
    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic run_directed();
        // Load the lowest and highest four words; their lines cover the wrap of the memory
        load_word(0, 32'h0000_0000);
        load_word(1, 32'hFFFF_FFFF);
        load_word(2, 32'hA5A5_5A5A);
        load_word(3, 32'h5A5A_A5A5);
        load_word(4092, 32'h0123_4567);
        load_word(4093, 32'h89AB_CDEF);
        load_word(4094, 32'hFEDC_BA98);
        load_word(4095, 32'hFFFF_FFFF);
        // Fill the ring: lowest address, highest address (line wraps to index 0), last lines
        tick_word(1'b0, 1'b0, 1'b1, 32'h0000_0000);
        tick_word(1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
        tick_word(1'b0, 1'b0, 1'b1, 32'h0000_3FF0);
        tick_word(1'b0, 1'b0, 1'b1, 32'hFFFF_FFFC);
        // Full ring: drop the fetch, then drop it again with a pop on the same tick
        tick_word(1'b0, 1'b0, 1'b1, 32'hFFFF_FFF0);
        tick_word(1'b0, 1'b1, 1'b1, 32'h8000_0000);
        tick_word(1'b0, 1'b0, 1'b0, 32'h0000_0000);
        tick_word(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
        // Squash with pop and fetch raised; both must be ignored
        tick_word(1'b1, 1'b1, 1'b1, 32'h0000_0000);
        // Pop of an empty ring still advances the head
        tick_word(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
        tick_word(1'b0, 1'b0, 1'b1, 32'h0000_3FF4);
        // Overwrite a word of the pending line before it fills, then let it count down
        load_word(4094, 32'h0000_0000);
        tick_word(1'b0, 1'b0, 1'b0, 32'h0000_0000);
        tick_word(1'b0, 1'b0, 1'b0, 32'h0000_0000);
        tick_word(1'b0, 1'b0, 1'b0, 32'h0000_0000);
        tick_word(1'b0, 1'b1, 1'b0, 32'h0000_0000);
    endtask

    // One stretch of random words with the given mix
    task automatic run_phase(input int count, input int fetch_pct, input int consume_pct,
                             input int load_pct);
        int   n;
        int   k;
        int   start;
        logic squash;
        logic consumed;
        logic fetch;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < load_pct)
            begin
                if ($urandom_range(9) == 0)
                begin
                    // Load a whole new line so the pool of fetchable lines grows
                    start = $urandom_range(MEM_WORDS - 1);
                    for (k = 0; k < LINE_WORDS; k++)
                        load_word((start + k) % MEM_WORDS, $urandom());
                end
                else if ($urandom_range(1) == 1)
                begin
                    // Rewrite a word of a live line, so fills must see fresh data
                    start = line_starts[$urandom_range(line_starts.size() - 1)];
                    load_word((start + $urandom_range(LINE_WORDS - 1)) % MEM_WORDS, $urandom());
                end
                else
                begin
                    load_word($urandom_range(MEM_WORDS - 1), $urandom());
                end
            end
            else
            begin
                squash   = ($urandom_range(99) < 3);
                consumed = ($urandom_range(99) < consume_pct);
                fetch    = ($urandom_range(99) < fetch_pct);
                // An ignored fetch reads nothing, so its address may be anything
                tick_word(squash, consumed, fetch,
                          (fetch && !squash) ? fetch_line_addr() : $urandom());
            end
        end
    endtask

    initial
    begin
        int phase;
        phase = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        drain_results();

        // Random phases; each ends with the sender paused until all results are in.
        // Every fourth phase runs with no idling on either side; phase one also
        // triggers the long receiver hold while fetches keep coming.
        while (words_sent < ITEM_TARGET)
        begin
            if (phase % 4 == 2)
            begin
                tx_idle_pct = 0;
                rx_stall_pct <= 0;
            end
            else
            begin
                tx_idle_pct = 38;
                rx_stall_pct <= 38;
            end
            if (phase == 1)
                hold_req <= ~hold_req;
            run_phase(60 + $urandom_range(60), 20 + $urandom_range(70),
                      10 + $urandom_range(70), 8 + $urandom_range(20));
            drain_results();
            phase++;
        end

        // Let any stray result word surface, then give the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
